### rtl/cset_pkg.sv
// Package for the call stack exclusive time profiler.
// Holds field widths, event and status codes, controller states and the
// command and status structs that join the controller and the datapath.
`timescale 1ns / 1ps
`default_nettype none

package cset_pkg;

    localparam int KIND_W = 2;
    localparam int ID_W = 6;
    localparam int TS_W = 32;
    localparam int STATUS_W = 2;

    localparam int DEF_NUM_FUNCS = 64;
    localparam int DEF_STACK_DEPTH = 64;

    localparam logic [TS_W-1:0] TS_MAX = {TS_W{1'b1}};

    typedef enum logic [KIND_W-1:0] {
        KIND_START = 2'd0,
        KIND_END   = 2'd1,
        KIND_READ  = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_UPDATE
    } state_t;

    typedef struct packed {
        logic clear_wr;
        logic capture;
        logic lookup;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
    } stat_t;

endpackage

`default_nettype wire

### rtl/call_stack_exclusive_time.sv
// Top level of the call stack exclusive time profiler.
// Joins the controller cset_ctrl and the datapath cset_dp. Depends on cset_pkg.
//
// Usage: each input word carries an event kind (func), a function id and a
// timestamp on a valid/ready channel. Start pushes an id and credits the time
// since the last mark to the function on top of the stack; end credits the
// elapsed time plus one to the top function and pops it; read returns one
// total. Every word gives exactly one result word on the output channel.
// After reset the totals memory is cleared, one entry per cycle, and no word
// is accepted until the clearing pass has written every entry.
// An accepted word goes through capture, the stack top lookup with
// the totals read, then the totals update. The result is valid in the cycle
// after the update, and no new word is taken until the update of the last
// one has committed, as set by the read-modify-write of the totals memory.
// The result stays in an output register until taken; a stalled receiver
// holds the update step and input ready stays low until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module call_stack_exclusive_time #(
    parameter int NUM_FUNCS = cset_pkg::DEF_NUM_FUNCS,
    parameter int STACK_DEPTH = cset_pkg::DEF_STACK_DEPTH
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [cset_pkg::KIND_W-1:0]   func,
    input  wire logic [cset_pkg::ID_W-1:0]     func_id,
    input  wire logic [cset_pkg::TS_W-1:0]     timestamp,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [cset_pkg::ID_W-1:0]          credited_id,
    output logic [cset_pkg::TS_W-1:0]          total_time,
    output logic                               credited,
    output logic [cset_pkg::STATUS_W-1:0]      status
);
    import cset_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    cset_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    cset_dp #(
        .NUM_FUNCS   (NUM_FUNCS),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .func        (func),
        .func_id     (func_id),
        .timestamp   (timestamp),
        .credited_id (credited_id),
        .total_time  (total_time),
        .credited    (credited),
        .status      (status)
    );

endmodule

`default_nettype wire

### rtl/cset_ctrl.sv
// Controller state machine of the call stack exclusive time profiler.
// Sequences the clearing pass and the lookup and update steps of each word.
// Depends on cset_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cset_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    input  wire cset_pkg::stat_t stat,
    output cset_pkg::cmd_t      cmd
);
    import cset_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (stat.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.capture = in_valid;
            end
            S_LOOKUP:
            begin
                cmd.lookup = 1'b1;
            end
            S_UPDATE:
            begin
                cmd.commit = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

### rtl/cset_dp.sv
// Datapath of the call stack exclusive time profiler.
// Holds the totals memory, the call stack memory, the stack depth, the time
// mark and the result register. Depends on cset_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cset_dp #(
    parameter int NUM_FUNCS = cset_pkg::DEF_NUM_FUNCS,
    parameter int STACK_DEPTH = cset_pkg::DEF_STACK_DEPTH
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire cset_pkg::cmd_t                cmd,
    output cset_pkg::stat_t                    stat,
    input  wire logic [cset_pkg::KIND_W-1:0]   func,
    input  wire logic [cset_pkg::ID_W-1:0]     func_id,
    input  wire logic [cset_pkg::TS_W-1:0]     timestamp,
    output logic [cset_pkg::ID_W-1:0]          credited_id,
    output logic [cset_pkg::TS_W-1:0]          total_time,
    output logic                               credited,
    output logic [cset_pkg::STATUS_W-1:0]      status
);
    import cset_pkg::*;

    localparam int IDX_W = (NUM_FUNCS > 1) ? $clog2(NUM_FUNCS) : 1;
    localparam int SP_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
    localparam int EXT_W = ID_W + IDX_W + 1;

    logic [TS_W-1:0]    totals_mem [NUM_FUNCS];
    logic [ID_W-1:0]    stack_mem [STACK_DEPTH];

    kind_t              kind_reg;
    logic [ID_W-1:0]    id_reg;
    logic [TS_W-1:0]    ts_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic [DEPTH_W-1:0] depth_next;
    logic [TS_W-1:0]    mark_reg;
    logic [TS_W-1:0]    mark_next;
    logic [IDX_W-1:0]   clr_idx_reg;
    logic [IDX_W-1:0]   clr_idx_next;
    logic [ID_W-1:0]    top_reg;
    logic [TS_W-1:0]    tot_rdata_reg;

    logic               cred_reg;
    logic               cred_next;
    logic               cwr_reg;
    logic               cwr_next;
    logic [ID_W-1:0]    cid_reg;
    logic [ID_W-1:0]    cid_next;
    logic [IDX_W-1:0]   caddr_reg;
    logic [IDX_W-1:0]   caddr_next;
    logic               push_reg;
    logic               push_next;
    logic               pop_reg;
    logic               pop_next;
    status_t            stat_reg;
    status_t            stat_next;
    logic [TS_W:0]      elapsed_reg;
    logic [TS_W:0]      elapsed_next;

    logic [ID_W-1:0]     credited_id_reg;
    logic [TS_W-1:0]     total_time_reg;
    logic                credited_reg;
    status_t             status_reg;

    logic               empty;
    logic               full;
    logic [DEPTH_W-1:0] depth_m1;
    logic [SP_W-1:0]    stack_raddr;
    logic [SP_W-1:0]    stack_waddr;
    logic [EXT_W-1:0]   cid_ext;
    logic               cid_in_range;
    logic [TS_W:0]      now;
    logic [TS_W+1:0]    sum;
    logic [TS_W-1:0]    sum_sat;
    logic               tot_we;
    logic [IDX_W-1:0]   tot_waddr;
    logic [TS_W-1:0]    tot_wdata;

    assign empty = (depth_reg == '0);
    assign full = (depth_reg == DEPTH_W'(STACK_DEPTH));
    assign depth_m1 = depth_reg - DEPTH_W'(1);
    assign stack_raddr = depth_m1[SP_W-1:0];
    assign stack_waddr = depth_reg[SP_W-1:0];

    // The word is captured when the controller accepts it.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= kind_t'(func);
            id_reg <= func_id;
            ts_reg <= timestamp;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && push_reg)
        begin
            stack_mem[stack_waddr] <= id_reg;
        end
        top_reg <= stack_mem[stack_raddr];
    end

    // Decide the effect of the word from the kind, the depth and the top id.
    always_comb
    begin
        cred_next = 1'b0;
        cwr_next = 1'b0;
        cid_next = '0;
        push_next = 1'b0;
        pop_next = 1'b0;
        stat_next = ST_OK;
        unique case (kind_reg)
            KIND_START:
            begin
                if (full)
                begin
                    stat_next = ST_OVERFLOW;
                end
                else
                begin
                    push_next = 1'b1;
                    cid_next = top_reg;
                    cred_next = !empty;
                end
            end
            KIND_END:
            begin
                if (empty)
                begin
                    stat_next = ST_UNDERFLOW;
                end
                else
                begin
                    pop_next = 1'b1;
                    cid_next = top_reg;
                    cred_next = 1'b1;
                end
            end
            KIND_READ:
            begin
                cid_next = id_reg;
                cred_next = 1'b1;
            end
            KIND_NONE:
            begin
                cred_next = 1'b0;
            end
            default:
            begin
                cred_next = 1'b0;
            end
        endcase
        cid_ext = {{(IDX_W + 1){1'b0}}, cid_next};
        cid_in_range = (cid_ext < EXT_W'(NUM_FUNCS));
        cred_next = cred_next && cid_in_range;
        cwr_next = cred_next && (kind_reg != KIND_READ);
        caddr_next = cid_ext[IDX_W-1:0];
    end

    always_comb
    begin
        if (kind_reg == KIND_END)
        begin
            now = {1'b0, ts_reg} + (TS_W + 1)'(1);
        end
        else
        begin
            now = {1'b0, ts_reg};
        end
        if ((kind_reg != KIND_READ) && (now >= {1'b0, mark_reg}))
        begin
            elapsed_next = now - {1'b0, mark_reg};
        end
        else
        begin
            elapsed_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            cred_reg <= cred_next;
            cwr_reg <= cwr_next;
            cid_reg <= cid_next;
            caddr_reg <= caddr_next;
            stat_reg <= stat_next;
            elapsed_reg <= elapsed_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push_reg <= 1'b0;
            pop_reg <= 1'b0;
        end
        else if (cmd.lookup)
        begin
            push_reg <= push_next;
            pop_reg <= pop_next;
        end
    end

    assign sum = {2'b00, tot_rdata_reg} + {1'b0, elapsed_reg};
    assign sum_sat = (sum[TS_W+1:TS_W] != 2'b00) ? TS_MAX : sum[TS_W-1:0];

    assign tot_we = cmd.clear_wr || (cmd.commit && cwr_reg);
    assign tot_waddr = cmd.clear_wr ? clr_idx_reg : caddr_reg;
    assign tot_wdata = cmd.clear_wr ? '0 : sum_sat;

    always_ff @(posedge clk)
    begin
        if (tot_we)
        begin
            totals_mem[tot_waddr] <= tot_wdata;
        end
        if (cmd.lookup)
        begin
            tot_rdata_reg <= totals_mem[caddr_next];
        end
    end

    always_comb
    begin
        clr_idx_next = clr_idx_reg;
        if (cmd.clear_wr)
        begin
            clr_idx_next = clr_idx_reg + IDX_W'(1);
        end
    end

    assign stat.clear_done = (clr_idx_reg == IDX_W'(NUM_FUNCS - 1));

    always_comb
    begin
        depth_next = depth_reg;
        mark_next = mark_reg;
        if (cmd.commit && push_reg)
        begin
            depth_next = depth_reg + DEPTH_W'(1);
            mark_next = ts_reg;
        end
        else if (cmd.commit && pop_reg)
        begin
            depth_next = depth_m1;
            mark_next = (ts_reg == TS_MAX) ? TS_MAX : ts_reg + TS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
            mark_reg <= '0;
            clr_idx_reg <= '0;
        end
        else
        begin
            depth_reg <= depth_next;
            mark_reg <= mark_next;
            clr_idx_reg <= clr_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            credited_id_reg <= cred_reg ? cid_reg : '0;
            total_time_reg <= cred_reg ? sum_sat : '0;
            credited_reg <= cred_reg;
            status_reg <= stat_reg;
        end
    end

    assign credited_id = credited_id_reg;
    assign total_time = total_time_reg;
    assign credited = credited_reg;
    assign status = status_reg;

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_W'(STACK_DEPTH))
        else $error("stack depth above its limit");

    a_push_pop_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(push_reg && pop_reg))
        else $error("push and pop decided for the same word");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && push_reg |=> depth_reg == $past(depth_reg) + DEPTH_W'(1))
        else $error("push did not grow the stack");

    a_credit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && cred_reg |-> stat_reg == ST_OK)
        else $error("credit reported with an error status");

endmodule

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for call_stack_exclusive_time: a directed table of words, then
// random call and return traffic, checked against the profiler model here (typed rows
// against their own expected result). Depends on cset_pkg and the RTL of the block only.

module tb;
    import cset_pkg::*;

    localparam int FUNC_COUNT = DEF_NUM_FUNCS;
    localparam int STACK_SIZE = DEF_STACK_DEPTH;
    localparam int RANDOM_PER_PHASE = 500;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [TS_W-1:0] total;
        logic            credited;
        status_t         status;
    } profile_t;

    typedef struct {
        kind_t           kind;
        logic [ID_W-1:0] id;
        logic [TS_W-1:0] ts;
        bit              typed;
        profile_t        want;
    } table_row_t;

    typedef enum int {
        MIX_BALANCED,
        MIX_DEEP,
        MIX_SHALLOW
    } mix_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [KIND_W-1:0]   func = '0;
    logic [ID_W-1:0]     func_id = '0;
    logic [TS_W-1:0]     timestamp = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [ID_W-1:0]     credited_id;
    logic [TS_W-1:0]     total_time;
    logic                credited;
    logic [STATUS_W-1:0] status;

    logic [TS_W-1:0] func_total [FUNC_COUNT];
    logic [ID_W-1:0] id_stack [STACK_SIZE];
    int              stack_fill;
    logic [TS_W-1:0] mark_ts;
    logic [TS_W-1:0] stamp_now;

    profile_t   expected_q [$];
    table_row_t directed_q [$];

    int error_count = 0;
    int result_count = 0;
    int word_count = 0;
    int overflow_count = 0;
    int underflow_count = 0;
    int saturate_count = 0;
    int blocked_count = 0;
    int tx_idle_pct = 27;
    int rx_idle_pct = 85;
    bit long_hold_req = 1'b0;
    bit long_hold_active = 1'b0;

    call_stack_exclusive_time u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .func_id     (func_id),
        .timestamp   (timestamp),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .credited_id (credited_id),
        .total_time  (total_time),
        .credited    (credited),
        .status      (status)
    );

    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic profile_t credit_top(logic [TS_W:0] now);
        profile_t          r;
        logic [ID_W-1:0]   top;
        logic [TS_W:0]     elapsed;
        logic [TS_W+1:0]   sum;
        top = id_stack[stack_fill-1];
        elapsed = (now >= {1'b0, mark_ts}) ? now - {1'b0, mark_ts} : '0;
        sum = {2'b00, func_total[top]} + {1'b0, elapsed};
        func_total[top] = (sum > {2'b00, TS_MAX}) ? TS_MAX : sum[TS_W-1:0];
        r.id = top;
        r.total = func_total[top];
        r.credited = 1'b1;
        r.status = ST_OK;
        return r;
    endfunction

    function automatic profile_t profile_event(kind_t k, logic [ID_W-1:0] id,
                                               logic [TS_W-1:0] ts);
        profile_t r;
        r = '0;
        case (k)
            KIND_START:
            begin
                if (stack_fill == STACK_SIZE)
                begin
                    r.status = ST_OVERFLOW;
                end
                else
                begin
                    if (stack_fill > 0)
                    begin
                        r = credit_top({1'b0, ts});
                    end
                    id_stack[stack_fill] = id;
                    stack_fill++;
                    mark_ts = ts;
                end
            end
            KIND_END:
            begin
                if (stack_fill == 0)
                begin
                    r.status = ST_UNDERFLOW;
                end
                else
                begin
                    r = credit_top({1'b0, ts} + 33'd1);
                    stack_fill--;
                    mark_ts = (ts == TS_MAX) ? TS_MAX : ts + 32'd1;
                end
            end
            KIND_READ:
            begin
                r.id = id;
                r.total = func_total[id];
                r.credited = 1'b1;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic logic [TS_W-1:0] next_stamp();
        int unsigned   pick;
        int unsigned   back;
        logic [TS_W:0] sum;
        pick = $urandom_range(99);
        if (pick < 60)
        begin
            sum = {1'b0, stamp_now} + 33'($urandom_range(20));
        end
        else if (pick < 75)
        begin
            sum = {1'b0, stamp_now};
        end
        else if (pick < 85)
        begin
            sum = {1'b0, stamp_now} + 33'($urandom_range(32'h0FFF_FFFF));
        end
        else if (pick < 92)
        begin
            back = $urandom_range(50);
            sum = (stamp_now > back) ? {1'b0, stamp_now - back} : '0;
        end
        else
        begin
            sum = {1'b0, $urandom()};
        end
        stamp_now = sum[TS_W] ? TS_MAX : sum[TS_W-1:0];
        return stamp_now;
    endfunction

    function automatic void add_row(kind_t k, int id, logic [TS_W-1:0] ts, bit typed,
                                    int w_id, logic [TS_W-1:0] w_total, bit w_cred,
                                    status_t w_status);
        table_row_t entry;
        entry.kind = k;
        entry.id = id[ID_W-1:0];
        entry.ts = ts;
        entry.typed = typed;
        entry.want.id = w_id[ID_W-1:0];
        entry.want.total = w_total;
        entry.want.credited = w_cred;
        entry.want.status = w_status;
        directed_q.insert(directed_q.size(), entry);
    endfunction

    task automatic send_word(kind_t k, logic [ID_W-1:0] id, logic [TS_W-1:0] ts,
                             bit typed, profile_t want);
        profile_t predicted;
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        func <= k;
        func_id <= id;
        timestamp <= ts;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        predicted = profile_event(k, id, ts);
        if (typed)
        begin
            predicted = want;
        end
        expected_q.insert(expected_q.size(), predicted);
        word_count++;
        if (predicted.status == ST_OVERFLOW)
        begin
            overflow_count++;
        end
        if (predicted.status == ST_UNDERFLOW)
        begin
            underflow_count++;
        end
        if (predicted.credited && predicted.total == TS_MAX)
        begin
            saturate_count++;
        end
    endtask

    task automatic random_word(mix_t mix);
        int unsigned     roll;
        kind_t           k;
        logic [ID_W-1:0] id;
        roll = $urandom_range(99);
        if (roll < 3)
        begin
            k = KIND_NONE;
        end
        else
        begin
            case (mix)
                MIX_DEEP:
                begin
                    k = (roll < 80) ? KIND_START : (roll < 90) ? KIND_END : KIND_READ;
                end
                MIX_SHALLOW:
                begin
                    k = (roll < 30) ? KIND_START : (roll < 80) ? KIND_END : KIND_READ;
                end
                default:
                begin
                    if (stack_fill == 0 && roll < 70)
                    begin
                        k = KIND_START;
                    end
                    else
                    begin
                        k = (roll < 45) ? KIND_START : (roll < 85) ? KIND_END : KIND_READ;
                    end
                end
            endcase
        end
        id = $urandom_range(1) ? ID_W'($urandom_range(7)) : ID_W'($urandom_range(63));
        send_word(k, id, next_stamp(), 1'b0, '0);
    endtask

    task automatic run_phase(int tx_pct, int rx_pct);
        int   sent;
        int   segment;
        int   len;
        mix_t mix;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        sent = 0;
        segment = 0;
        while (sent < RANDOM_PER_PHASE)
        begin
            mix = mix_t'(segment % 3);
            len = (mix == MIX_DEEP) ? $urandom_range(140, 100) : $urandom_range(100, 40);
            if (len > RANDOM_PER_PHASE - sent)
            begin
                len = RANDOM_PER_PHASE - sent;
            end
            repeat (len) random_word(mix);
            sent += len;
            segment++;
        end
    endtask

    initial
    begin
        int unsigned held;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                long_hold_active = 1'b1;
                for (held = 0; held < LONG_HOLD_CYCLES; held++)
                begin
                    out_ready <= 1'b0;
                    @(negedge clk);
                end
                long_hold_active = 1'b0;
            end
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        profile_t want;
        if (long_hold_active && in_valid && !in_ready)
        begin
            blocked_count++;
        end
        if (rst_n && out_valid && out_ready)
        begin
            result_count++;
            if (expected_q.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                begin
                    $display("Unexpected result word: id %0d total %h credited %b status %0d",
                             credited_id, total_time, credited, status);
                end
            end
            else
            begin
                want = expected_q.pop_front();
                if (credited_id !== want.id || total_time !== want.total
                    || credited !== want.credited || status !== want.status)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                    begin
                        $display("Mismatch on result %0d: expected id %0d total %h cred %b st %0d",
                                 result_count, want.id, want.total, want.credited, want.status);
                        $display("    got id %0d total %h cred %b st %0d",
                                 credited_id, total_time, credited, status);
                    end
                end
            end
        end
    end

    initial
    begin
        for (int i = 0; i < FUNC_COUNT; i++)
        begin
            func_total[i] = '0;
        end
        stack_fill = 0;
        mark_ts = '0;
        stamp_now = '0;

        add_row(KIND_READ,  0,  32'd0,  1, 0,  32'd0,  1'b1, ST_OK);
        add_row(KIND_READ,  63, 32'd0,  1, 63, 32'd0,  1'b1, ST_OK);
        add_row(KIND_END,   0,  32'd0,  1, 0,  32'd0,  1'b0, ST_UNDERFLOW);
        add_row(KIND_NONE,  63, TS_MAX, 1, 0,  32'd0,  1'b0, ST_OK);
        add_row(KIND_START, 5,  32'd0,  1, 0,  32'd0,  1'b0, ST_OK);
        add_row(KIND_START, 63, 32'd10, 0, 0,  32'd0,  1'b0, ST_OK);
        add_row(KIND_END,   0,  32'd20, 0, 0,  32'd0,  1'b0, ST_OK);
        add_row(KIND_END,   0,  32'd30, 0, 0,  32'd0,  1'b0, ST_OK);
        add_row(KIND_START, 7,  32'd100, 1, 0, 32'd0,  1'b0, ST_OK);
        add_row(KIND_START, 8,  32'd50, 0, 0,  32'd0,  1'b0, ST_OK);
        add_row(KIND_END,   0,  32'd40, 0, 0,  32'd0,  1'b0, ST_OK);
        add_row(KIND_END,   0,  32'd60, 0, 0,  32'd0,  1'b0, ST_OK);
        add_row(KIND_END,   63, 32'd70, 1, 0,  32'd0,  1'b0, ST_UNDERFLOW);
        add_row(KIND_START, 9,  32'd0,  1, 0,  32'd0,  1'b0, ST_OK);
        add_row(KIND_END,   63, TS_MAX, 1, 9,  TS_MAX, 1'b1, ST_OK);
        add_row(KIND_START, 9,  TS_MAX, 1, 0,  32'd0,  1'b0, ST_OK);
        add_row(KIND_END,   0,  TS_MAX, 0, 0,  32'd0,  1'b0, ST_OK);
        add_row(KIND_READ,  9,  TS_MAX, 1, 9,  TS_MAX, 1'b1, ST_OK);
        add_row(KIND_READ,  5,  TS_MAX, 0, 0,  32'd0,  1'b0, ST_OK);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_q[i])
        begin
            send_word(directed_q[i].kind, directed_q[i].id, directed_q[i].ts,
                      directed_q[i].typed, directed_q[i].want);
        end

        run_phase(27, 85);
        run_phase(85, 27);
        long_hold_req = 1'b1;
        run_phase(0, 0);

        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d words and checked %0d results, %0d mismatches.",
                 word_count, result_count, error_count);
        $display("Saw %0d full-stack and %0d empty-stack events, %0d saturated totals, %0d %s",
                 overflow_count, underflow_count, saturate_count, blocked_count,
                 "input cycles stalled during the long output hold.");
        if (error_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/cset_pkg.sv
rtl/cset_ctrl.sv
rtl/cset_dp.sv
rtl/call_stack_exclusive_time.sv
tb/sv/tb.sv
